// ----- rtl/pee_pkg.sv -----
// Shared types and constants for the prefix expression evaluator.
// No dependencies; the files that use it refer to this package by scoped names.
package pee_pkg;

   // Token kinds.
   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_INT = 3'd4;
   localparam logic [2:0] FUNC_END = 3'd5;

   // Operator codes as kept in a stack entry.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_DIVZERO    = 3'd1;
   localparam logic [2:0] ST_OVERFLOW   = 3'd2;
   localparam logic [2:0] ST_INCOMPLETE = 3'd3;
   localparam logic [2:0] ST_INVALID    = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [30:0] literal;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         status;
   } rsp_type;

   // One pending operator on the stack.
   typedef struct packed {
      logic [1:0]  op;
      logic        has_left;
      logic [31:0] left;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_token;
      logic       push;
      logic       set_left;
      logic       pop;
      logic       pop_div;
      logic       div_start;
      logic       clear;
      logic       emit;
      logic [2:0] status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] func;
      logic       level_zero;
      logic       level_one;
      logic       level_full;
      logic       top_has_left;
      logic       top_is_div;
      logic       divisor_zero;
      logic       div_done;
      logic       out_free;
   } sts_type;

endpackage

// ----- rtl/pee_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pee_divider.sv -----
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// No package dependencies.
module pee_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   localparam int STEPS = 32;
   localparam int CNT_W = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [31:0]      den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = !diff[32];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         den_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         // Shift the next dividend bit into the remainder; subtract if it fits.
         rem_in = fits ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

// ----- rtl/pee_datapath.sv -----
// Datapath: operator stack in RAM, stack level, current value, ALU,
// divider and the result register. Uses pee_pkg, pee_ram, pee_divider.
module pee_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  pee_pkg::req_type  req_data,
   output pee_pkg::rsp_type  rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pee_pkg::cmd_type  cmd,
   output pee_pkg::sts_type  sts
);

   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int ENT_W  = $bits(pee_pkg::entry_type);

   logic [LVL_W-1:0]  level_ff, level_in;
   logic [31:0]       val_ff, val_in;
   logic [2:0]        func_ff, func_in;
   pee_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [LVL_W-1:0]   level_m1;
   logic [ADDR_W-1:0]  top_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   pee_pkg::entry_type wr_entry;
   logic [ENT_W-1:0]   rd_bits;
   pee_pkg::entry_type top;
   logic [31:0]        alu;
   logic [31:0]        product;
   logic               div_done;
   logic [31:0]        div_q;

   assign level_m1 = level_ff - 1'b1;
   assign top_addr = level_m1[ADDR_W-1:0];

   // The read port always follows the top entry; its data is registered, so it lags the level.
   always_comb begin
      wr_en    = cmd.push || cmd.set_left;
      wr_addr  = top_addr;
      wr_entry = '0;
      if (cmd.push) begin
         wr_addr     = level_ff[ADDR_W-1:0];
         wr_entry.op = func_ff[1:0];
      end else begin
         wr_entry.op       = top.op;
         wr_entry.has_left = 1'b1;
         wr_entry.left     = val_ff;
      end
   end

   pee_ram #(
      .WIDTH(ENT_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (top_addr),
      .rd_data (rd_bits)
   );

   assign top = pee_pkg::entry_type'(rd_bits);

   pee_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (top.left),
      .divisor  (val_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign product = top.left * val_ff;

   always_comb begin
      case (top.op)
         pee_pkg::OP_ADD: alu = top.left + val_ff;
         pee_pkg::OP_SUB: alu = top.left - val_ff;
         pee_pkg::OP_MUL: alu = product;
         default:         alu = div_q;
      endcase
   end

   always_comb begin
      level_in     = level_ff;
      val_in       = val_ff;
      func_in      = func_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_token) begin
         func_in = req_data.func;
         val_in  = {1'b0, req_data.literal};
      end
      if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.push) begin
         level_in = level_ff + 1'b1;
      end else if (cmd.pop) begin
         level_in = level_m1;
         val_in   = cmd.pop_div ? div_q : alu;
      end
      if (cmd.emit) begin
         rsp_in.status = cmd.status;
         rsp_in.value  = (cmd.status == pee_pkg::ST_OK) ? $signed(val_ff) : 32'sd0;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff  <= val_in;
      func_ff <= func_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign sts.func         = func_ff;
   assign sts.level_zero   = (level_ff == '0);
   assign sts.level_one    = (level_ff == LVL_W'(1));
   assign sts.level_full   = (level_ff == LVL_W'(STACK_DEPTH));
   assign sts.top_has_left = top.has_left;
   assign sts.top_is_div   = (top.op == pee_pkg::OP_DIV);
   assign sts.divisor_zero = (val_ff == 32'd0);
   assign sts.div_done     = div_done;
   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;

endmodule

// ----- rtl/pee_ctrl.sv -----
// Controller state machine: token decode, pop chain sequencing, errors
// and result hand-off. Uses pee_pkg.
module pee_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pee_pkg::sts_type sts,
   output pee_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_EVAL   = 6'b000100,
      S_DIV    = 6'b001000,
      S_FETCH  = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] status_ff, status_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_token = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.func) inside
               pee_pkg::FUNC_ADD, pee_pkg::FUNC_SUB,
               pee_pkg::FUNC_MUL, pee_pkg::FUNC_DIV: begin
                  if (sts.level_full) begin
                     cmd.clear = 1'b1;
                     status_in = pee_pkg::ST_OVERFLOW;
                     state_in  = S_EMIT;
                  end else begin
                     cmd.push = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               pee_pkg::FUNC_END: begin
                  if (!sts.level_zero) begin
                     cmd.clear = 1'b1;
                     status_in = pee_pkg::ST_INCOMPLETE;
                     state_in  = S_EMIT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               pee_pkg::FUNC_INT: begin
                  if (sts.level_zero) begin
                     status_in = pee_pkg::ST_OK;
                     state_in  = S_EMIT;
                  end else begin
                     state_in = S_EVAL;
                  end
               end
               default: begin
                  cmd.clear = 1'b1;
                  status_in = pee_pkg::ST_INVALID;
                  state_in  = S_EMIT;
               end
            endcase
         end
         S_EVAL: begin
            if (!sts.top_has_left) begin
               cmd.set_left = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.top_is_div) begin
               if (sts.divisor_zero) begin
                  cmd.clear = 1'b1;
                  status_in = pee_pkg::ST_DIVZERO;
                  state_in  = S_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.pop   = 1'b1;
               status_in = pee_pkg::ST_OK;
               state_in  = sts.level_one ? S_EMIT : S_FETCH;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.pop     = 1'b1;
               cmd.pop_div = 1'b1;
               status_in   = pee_pkg::ST_OK;
               state_in    = sts.level_one ? S_EMIT : S_FETCH;
            end
         end
         S_FETCH: begin
            // The stack read port is registered; this state waits for it to show the new top entry.
            state_in = S_EVAL;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

endmodule

// ----- rtl/prefix_expression_evaluator.sv -----
// Channel   Direction  Payload             Handshake
// req       in         pee_pkg::req_type   req_valid / req_stall
// rsp       out        pee_pkg::rsp_type   rsp_valid / rsp_stall
//
// One token at a time; an operator or end token passes through decode, a literal
// through decode, then one evaluate step per stack entry it reaches and a fetch step
// between evaluations. A division waits on the divider; a result passes through emit.
// Reset empties the stack; stack entries are written on push before any read.
// A result waits in the output register while stalled; tokens that produce no
// result keep flowing, and a token that does waits until the register frees.
// Top level of the prefix expression evaluator; uses pee_pkg, pee_ctrl and
// pee_datapath.
module prefix_expression_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pee_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pee_pkg::rsp_type rsp_data
);

   pee_pkg::cmd_type cmd;
   pee_pkg::sts_type sts;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pee_datapath #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ----- tb/prefix_expression_evaluator_tb.sv -----
// Self-checking testbench for prefix_expression_evaluator: directed and random token
// streams with bursty sending and a stalling receiver, checked against an in-bench
// evaluator. Depends on pee_pkg and the prefix_expression_evaluator RTL.
`timescale 1ns / 1ps

module prefix_expression_evaluator_tb;

   localparam int STACK_DEPTH = 16;
   localparam int RANDOM_TOKENS = 1750;
   localparam int DRAIN_CYCLES = 1000;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int MAX_REPORTS = 10;

   // Token codes that the block must reject.
   localparam logic [2:0] FUNC_BAD_LO = 3'd6;
   localparam logic [2:0] FUNC_BAD_HI = 3'd7;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pee_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pee_pkg::rsp_type rsp_data;

   pee_pkg::req_type token_queue[$];
   pee_pkg::rsp_type expected_results[$];
   int               total_tokens;
   int               tokens_sent = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               burst_left;
   int               gap_left;
   int               stall_window = 0;
   int               stall_mode = 0;
   pee_pkg::rsp_type wanted;

   // Evaluator state: pending operators and their first operands.
   logic [1:0]  op_stack[STACK_DEPTH];
   logic        left_known[STACK_DEPTH];
   logic [31:0] left_stack[STACK_DEPTH];
   int          depth_used = 0;

   prefix_expression_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic void expect_result(logic [31:0] value, logic [2:0] status);
      pee_pkg::rsp_type r;
      r.value = value;
      r.status = status;
      expected_results.push_back(r);
   endfunction

   function automatic void abort_expression(logic [2:0] status);
      depth_used = 0;
      expect_result('0, status);
   endfunction

   function automatic logic [31:0] quotient_toward_zero(logic [31:0] dividend,
                                                        logic [31:0] divisor);
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] q;
      mag_a = dividend[31] ? -dividend : dividend;
      mag_b = divisor[31] ? -divisor : divisor;
      q = mag_a / mag_b;
      return (dividend[31] ^ divisor[31]) ? -q : q;
   endfunction

   function automatic void evaluate_token(pee_pkg::req_type tok);
      logic [31:0] operand;
      logic [31:0] first;
      int          top;
      operand = {1'b0, tok.literal};
      case (tok.func)
         pee_pkg::FUNC_ADD, pee_pkg::FUNC_SUB,
         pee_pkg::FUNC_MUL, pee_pkg::FUNC_DIV: begin
            if (depth_used >= STACK_DEPTH) begin
               abort_expression(pee_pkg::ST_OVERFLOW);
            end else begin
               op_stack[depth_used] = tok.func[1:0];
               left_known[depth_used] = 1'b0;
               left_stack[depth_used] = '0;
               depth_used++;
            end
         end
         pee_pkg::FUNC_END: begin
            if (depth_used != 0) abort_expression(pee_pkg::ST_INCOMPLETE);
         end
         pee_pkg::FUNC_INT: begin
            // A value either fills the top operator or completes it; completed
            // operators pop and hand their result further down.
            while (depth_used != 0) begin
               top = depth_used - 1;
               if (!left_known[top]) begin
                  left_known[top] = 1'b1;
                  left_stack[top] = operand;
                  return;
               end
               first = left_stack[top];
               case (op_stack[top])
                  pee_pkg::OP_ADD: operand = first + operand;
                  pee_pkg::OP_SUB: operand = first - operand;
                  pee_pkg::OP_MUL: operand = first * operand;
                  default: begin
                     if (operand == 0) begin
                        abort_expression(pee_pkg::ST_DIVZERO);
                        return;
                     end
                     operand = quotient_toward_zero(first, operand);
                  end
               endcase
               depth_used = top;
            end
            expect_result(operand, pee_pkg::ST_OK);
         end
         default: abort_expression(pee_pkg::ST_INVALID);
      endcase
   endfunction

   function automatic void add_token(logic [2:0] func, logic [30:0] literal);
      pee_pkg::req_type t;
      t.func = func;
      t.literal = literal;
      token_queue.push_back(t);
   endfunction

   function automatic logic [30:0] random_literal();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 31'd1;
         2: return '1;
         3, 4: return 31'($urandom_range(0, 15));
         5: return 31'($urandom_range(0, 1000));
         default: return 31'($urandom);
      endcase
   endfunction

   // Emits one well-formed prefix expression. Nesting never exceeds the stack,
   // and past the token budget only literals are added so the tree closes.
   function automatic void add_expression(int op_pct, int budget);
      bit slot_filled[STACK_DEPTH];
      int nest;
      int emitted;
      bit finished;
      nest = 0;
      emitted = 0;
      finished = 1'b0;
      while (!finished) begin
         if (nest < STACK_DEPTH && emitted < budget && $urandom_range(1, 100) <= op_pct) begin
            add_token(3'($urandom_range(0, 3)), 31'($urandom));
            slot_filled[nest] = 1'b0;
            nest++;
         end else begin
            add_token(pee_pkg::FUNC_INT, random_literal());
            finished = 1'b1;
            while (nest > 0 && finished) begin
               if (!slot_filled[nest-1]) begin
                  slot_filled[nest-1] = 1'b1;
                  finished = 1'b0;
               end else begin
                  nest--;
               end
            end
         end
         emitted++;
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            evaluate_token(req_data);
            tokens_sent++;
         end
         if (gap_left > 0 || token_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_data <= token_queue.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Receiver: checks each beat and stalls in windows of varying density.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: value %0d status %0d",
                           rsp_data.value, rsp_data.status);
            end else begin
               wanted = expected_results.pop_front();
               if (rsp_data.value !== wanted.value || rsp_data.status !== wanted.status) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("result mismatch: value exp %0d got %0d, status exp %0d got %0d",
                              wanted.value, rsp_data.value, wanted.status, rsp_data.status);
               end
            end
         end
         if (stall_window == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_window = $urandom_range(8, 64);
         end
         stall_window--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 4) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int r;
      int k;
      int stop_at;

      add_token(pee_pkg::FUNC_END, '0);
      // (max * max + max) wraps to the most negative value, then divide by -1.
      add_token(pee_pkg::FUNC_DIV, '0);
      add_token(pee_pkg::FUNC_ADD, '0);
      add_token(pee_pkg::FUNC_MUL, '0);
      repeat (3) add_token(pee_pkg::FUNC_INT, '1);
      add_token(pee_pkg::FUNC_SUB, '1);
      add_token(pee_pkg::FUNC_INT, '0);
      add_token(pee_pkg::FUNC_INT, 31'd1);
      add_token(pee_pkg::FUNC_DIV, '1);
      add_token(pee_pkg::FUNC_INT, 31'd7);
      add_token(pee_pkg::FUNC_INT, '0);
      add_token(pee_pkg::FUNC_SUB, '0);
      add_token(pee_pkg::FUNC_END, '1);
      add_token(FUNC_BAD_LO, '0);
      add_token(FUNC_BAD_HI, '1);
      repeat (STACK_DEPTH + 1) add_token(3'($urandom_range(0, 3)), 31'($urandom));
      add_token(pee_pkg::FUNC_END, '0);

      stop_at = token_queue.size() + RANDOM_TOKENS;
      while (token_queue.size() < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            add_expression(45, 30);
            if ($urandom_range(0, 9) == 0) add_token(pee_pkg::FUNC_END, 31'($urandom));
         end else if (r < 70) begin
            add_expression(75, 48);
         end else if (r < 78) begin
            // A straight chain; one deeper than the stack overflows it.
            k = $urandom_range(10, STACK_DEPTH + 1);
            repeat (k) add_token(3'($urandom_range(0, 3)), 31'($urandom));
            repeat (k + 1) add_token(pee_pkg::FUNC_INT, random_literal());
         end else if (r < 86) begin
            repeat ($urandom_range(1, 3)) add_token(3'($urandom_range(0, 3)), 31'($urandom));
            if ($urandom_range(0, 1)) add_token(pee_pkg::FUNC_INT, random_literal());
            add_token(pee_pkg::FUNC_END, 31'($urandom));
         end else if (r < 92) begin
            repeat ($urandom_range(0, 2)) add_token(3'($urandom_range(0, 3)), 31'($urandom));
            add_token($urandom_range(0, 1) ? FUNC_BAD_LO : FUNC_BAD_HI, 31'($urandom));
         end else begin
            add_token(3'($urandom_range(0, 7)), random_literal());
         end
      end
      total_tokens = token_queue.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (tokens_sent < total_tokens) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pee_pkg.sv
rtl/pee_ram.sv
rtl/pee_divider.sv
rtl/pee_datapath.sv
rtl/pee_ctrl.sv
rtl/prefix_expression_evaluator.sv
tb/prefix_expression_evaluator_tb.sv
